### hdl/swrt_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window range tracker package
// Shared widths, register indexes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package swrt_pkg;

  localparam int DATA_W         = 32;
  localparam int WLEN_W         = 7;
  localparam int CFG_IDX_W      = 2;
  localparam int WINDOW_MAX_DEF = 64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDED_COUNT = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // take the input word and store the sample
    logic rd_issue;  // read one older sample from the store
    logic range_en;  // register max minus min
    logic update;    // update the smallest range and the over count
    logic finish;    // load the result register, clear at end of sequence
  } swrt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic win_full;   // the word being accepted completes a window
    logic len_one;    // effective window length is one
    logic last_read;  // the read issued now is the final one of the scan
  } swrt_sts_t;

endpackage

`default_nettype wire

### hdl/swrt_dp.sv
// ----------------------------------------------------------------------------
// Sliding window range tracker datapath
// Sample store, max/min scan, range statistics and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module swrt_dp #(
  parameter int WINDOW_MAX = swrt_pkg::WINDOW_MAX_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire swrt_pkg::swrt_cmd_t             cmd,
  output swrt_pkg::swrt_sts_t                  sts,
  input  wire logic [swrt_pkg::WLEN_W-1:0]     window_len,
  input  wire logic [swrt_pkg::DATA_W-1:0]     threshold,
  input  wire logic [swrt_pkg::DATA_W-1:0]     needed_count,
  input  wire logic signed [swrt_pkg::DATA_W-1:0] in_sample,
  input  wire logic                            in_last_sample,
  output logic                                 out_window_ready,
  output logic [swrt_pkg::DATA_W-1:0]          out_range,
  output logic [swrt_pkg::DATA_W-1:0]          out_min_range,
  output logic [swrt_pkg::DATA_W-1:0]          out_over_count,
  output logic                                 out_reached,
  output logic                                 out_is_last
);
  import swrt_pkg::*;

  localparam int ADDR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
  localparam int CMP_W  = (LEN_W > WLEN_W) ? LEN_W : WLEN_W;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WINDOW_MAX - 1);
  localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(WINDOW_MAX);
  localparam logic [DATA_W-1:0] ALL_ONES  = '1;

  logic signed [DATA_W-1:0] mem [WINDOW_MAX];

  logic [ADDR_W-1:0]        wp_r, rd_ptr_r;
  logic [LEN_W-1:0]         pos_r, rem_r;
  logic signed [DATA_W-1:0] rd_data_r, hi_r, lo_r;
  logic                     rd_vld_r;
  logic                     full_r, last_r;
  logic [DATA_W-1:0]        rng_r, smallest_r, cnt_r;

  logic [CMP_W-1:0]   wl_ext;
  logic [LEN_W-1:0]   eff_len, pos_nxt;
  logic [ADDR_W-1:0]  wp_nxt, wp_prev, rd_prev;
  logic [DATA_W:0]    diff;

  always_comb begin
    wl_ext = CMP_W'(window_len);
    if (wl_ext == '0) begin
      eff_len = LEN_W'(1);
    end else if (wl_ext > CMP_W'(WINDOW_MAX)) begin
      eff_len = LEN_MAX;
    end else begin
      eff_len = wl_ext[LEN_W-1:0];
    end
    pos_nxt = (pos_r == LEN_MAX) ? pos_r : pos_r + LEN_W'(1);
    wp_nxt  = (wp_r == LAST_ADDR) ? '0 : wp_r + ADDR_W'(1);
    wp_prev = (wp_r == '0) ? LAST_ADDR : wp_r - ADDR_W'(1);
    rd_prev = (rd_ptr_r == '0) ? LAST_ADDR : rd_ptr_r - ADDR_W'(1);
    diff    = {hi_r[DATA_W-1], hi_r} - {lo_r[DATA_W-1], lo_r};
  end

  assign sts.win_full  = (pos_nxt >= eff_len);
  assign sts.len_one   = (eff_len == LEN_W'(1));
  assign sts.last_read = (rem_r == LEN_W'(1));

  // Sample store: one write on acceptance, one registered read per scan step.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mem[wp_r] <= in_sample;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_issue;
    end
  end

  // Scan registers; the newest sample seeds both extremes.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      hi_r     <= in_sample;
      lo_r     <= in_sample;
      rd_ptr_r <= wp_prev;
      rem_r    <= eff_len - LEN_W'(1);
      full_r   <= sts.win_full;
      last_r   <= in_last_sample;
      rng_r    <= '0;
    end else begin
      if (rd_vld_r) begin
        if (rd_data_r > hi_r) begin
          hi_r <= rd_data_r;
        end
        if (rd_data_r < lo_r) begin
          lo_r <= rd_data_r;
        end
      end
      if (cmd.rd_issue) begin
        rd_ptr_r <= rd_prev;
        rem_r    <= rem_r - LEN_W'(1);
      end
      if (cmd.range_en) begin
        rng_r <= diff[DATA_W-1:0];
      end
    end
  end

  // Sequence state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      pos_r      <= '0;
      smallest_r <= ALL_ONES;
      cnt_r      <= '0;
    end else begin
      if (cmd.accept) begin
        wp_r  <= wp_nxt;
        pos_r <= pos_nxt;
      end
      if (cmd.update) begin
        if (rng_r < smallest_r) begin
          smallest_r <= rng_r;
        end
        if ((rng_r >= threshold) && (cnt_r != ALL_ONES)) begin
          cnt_r <= cnt_r + DATA_W'(1);
        end
      end
      if (cmd.finish && last_r) begin
        wp_r       <= '0;
        pos_r      <= '0;
        smallest_r <= ALL_ONES;
        cnt_r      <= '0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_window_ready <= full_r;
      out_range        <= rng_r;
      out_min_range    <= smallest_r;
      out_over_count   <= cnt_r;
      out_reached      <= (cnt_r >= needed_count);
      out_is_last      <= last_r;
    end
  end

`ifndef SYNTHESIS
  a_seed_extremes: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (hi_r == lo_r))
    else $error("extremes not seeded from the accepted sample");

  a_seq_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && last_r) |=> (pos_r == '0 && wp_r == '0 && cnt_r == '0 &&
                                smallest_r == ALL_ONES))
    else $error("sequence state not cleared after the final word");
`endif

endmodule

`default_nettype wire

### hdl/swrt_ctrl.sv
// ----------------------------------------------------------------------------
// Sliding window range tracker controller
// Sequences acceptance, the store scan, statistics update and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module swrt_ctrl (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire                      out_ready,
  output swrt_pkg::swrt_cmd_t      cmd,
  input  wire swrt_pkg::swrt_sts_t sts
);
  import swrt_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_RANGE  = 3'd3;
  localparam logic [2:0] ST_UPDATE = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          if (!sts.win_full) begin
            state_nxt = ST_FINISH;
          end else if (sts.len_one) begin
            state_nxt = ST_RANGE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.rd_issue = 1'b1;
        if (sts.last_read) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_RANGE;
      end
      ST_RANGE: begin
        cmd.range_en = 1'b1;
        state_nxt    = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word accepted while one is in progress");

  a_finish_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && !out_valid_r) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished word not placed in the result register");
`endif

endmodule

`default_nettype wire

### hdl/sliding_window_range_tracker.sv
// ----------------------------------------------------------------------------
// Sliding window range tracker
// Range, smallest range and threshold count over a sliding window of samples.
// ----------------------------------------------------------------------------
// The block takes one signed 32-bit sample per input word and returns one
// result word for each. Once window_len samples of the current sequence have
// arrived, the result carries the range (maximum minus minimum) of the newest
// window_len samples, the smallest such range seen in the sequence, and a
// saturating count of windows whose range is at least threshold, with reached
// raised once that count is at least needed_count. A word with last_sample
// set ends the sequence: its result is produced normally and the sequence
// state is cleared afterwards; the configuration registers keep their
// values. A window length of zero acts as one, and a length above WINDOW_MAX
// acts as WINDOW_MAX. Samples are kept in a single-port store of WINDOW_MAX
// entries, and the maximum and minimum are found by reading the older
// samples of the window back one per clock. A word that does not yet complete
// a window goes from acceptance straight to the final state, where its result
// is loaded into the output register. A word that completes the window waits
// for the scan, one read per clock for each older sample, then for a step
// each for the final compare, the range and the statistics before its result
// is loaded; a window of one skips the scan. The controller is back in idle
// once the result is loaded. A result still waiting in the output register
// holds the controller in its final state until it is taken. Only one word
// is in progress at a time, but a new word is accepted while the previous
// result still waits in the output register. Configuration words are always
// accepted and must only be sent while the block is idle.
`default_nettype none

module sliding_window_range_tracker #(
  parameter int WINDOW_MAX = swrt_pkg::WINDOW_MAX_DEF
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  // Configuration write channel.
  input  wire                                     cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [swrt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [swrt_pkg::DATA_W-1:0]        cfg_data,
  // Input channel.
  input  wire                                     in_valid,
  output logic                                    in_ready,
  input  wire logic signed [swrt_pkg::DATA_W-1:0] in_sample,
  input  wire logic                               in_last_sample,
  // Result channel.
  output logic                                    out_valid,
  input  wire                                     out_ready,
  output logic                                    out_window_ready,
  output logic [swrt_pkg::DATA_W-1:0]             out_range,
  output logic [swrt_pkg::DATA_W-1:0]             out_min_range,
  output logic [swrt_pkg::DATA_W-1:0]             out_over_count,
  output logic                                    out_reached,
  output logic                                    out_is_last
);
  import swrt_pkg::*;

  logic [WLEN_W-1:0] window_len_r;
  logic [DATA_W-1:0] threshold_r;
  logic [DATA_W-1:0] needed_count_r;

  swrt_cmd_t cmd;
  swrt_sts_t sts;

  // Configuration registers. A write to an index beyond the list is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r   <= WLEN_W'(1);
      threshold_r    <= '0;
      needed_count_r <= DATA_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WINDOW_LEN:   window_len_r   <= cfg_data[WLEN_W-1:0];
        REG_THRESHOLD:    threshold_r    <= cfg_data;
        REG_NEEDED_COUNT: needed_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // The controller owns the handshakes and sequencing; the datapath holds
  // the sample store, the running extremes and the sequence statistics.
  swrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  swrt_dp #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .window_len       (window_len_r),
    .threshold        (threshold_r),
    .needed_count     (needed_count_r),
    .in_sample        (in_sample),
    .in_last_sample   (in_last_sample),
    .out_window_ready (out_window_ready),
    .out_range        (out_range),
    .out_min_range    (out_min_range),
    .out_over_count   (out_over_count),
    .out_reached      (out_reached),
    .out_is_last      (out_is_last)
  );

endmodule

`default_nettype wire

### bench/swrt_range_checker.sv
// ----------------------------------------------------------------------------
// Sliding window range tracker checker
// Watches the configuration, input and result channels, predicts each result
// word from its own copy of the sequence state and compares field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module swrt_range_checker #(
  parameter int WINDOW_MAX = swrt_pkg::WINDOW_MAX_DEF
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire                                     cfg_valid,
  input  wire                                     cfg_ready,
  input  wire logic [swrt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [swrt_pkg::DATA_W-1:0]        cfg_data,
  input  wire                                     in_valid,
  input  wire                                     in_ready,
  input  wire logic signed [swrt_pkg::DATA_W-1:0] in_sample,
  input  wire logic                               in_last_sample,
  input  wire                                     out_valid,
  input  wire                                     out_ready,
  input  wire logic                               out_window_ready,
  input  wire logic [swrt_pkg::DATA_W-1:0]        out_range,
  input  wire logic [swrt_pkg::DATA_W-1:0]        out_min_range,
  input  wire logic [swrt_pkg::DATA_W-1:0]        out_over_count,
  input  wire logic                               out_reached,
  input  wire logic                               out_is_last,
  output int                                      mismatches,
  output int                                      pending
);

  timeunit 1ns;
  timeprecision 1ps;

  import swrt_pkg::*;

  typedef struct packed {
    logic              win_full;
    logic [DATA_W-1:0] span;
    logic [DATA_W-1:0] min_span;
    logic [DATA_W-1:0] over_cnt;
    logic              reached;
    logic              is_last;
  } range_word_t;

  range_word_t range_words_due[$];
  range_word_t due;

  // Register copies.
  logic [WLEN_W-1:0] win_len;
  logic [DATA_W-1:0] span_threshold;
  logic [DATA_W-1:0] needed;

  // Sequence state.
  logic signed [DATA_W-1:0] sample_ring[WINDOW_MAX];
  int unsigned              wr_ptr;
  logic [DATA_W-1:0]        taken;
  logic [DATA_W-1:0]        smallest;
  logic [DATA_W-1:0]        qualifying;

  int fault_count = 0;

  assign mismatches = fault_count;

  initial pending = 0;

  function automatic void clear_sequence();
    wr_ptr     = 0;
    taken      = '0;
    smallest   = '1;
    qualifying = '0;
  endfunction

  // Stores the sample, then scans the newest window (the sample just stored
  // included) for its extremes and updates the running figures.
  function automatic range_word_t predict_range_word(logic signed [DATA_W-1:0] s, logic last);
    int unsigned         eff;
    int unsigned         pos;
    logic signed [DATA_W:0] hi;
    logic signed [DATA_W:0] lo;
    logic signed [DATA_W:0] diff;
    range_word_t         w;
    if (win_len == 0) eff = 1;
    else if (int'(win_len) > WINDOW_MAX) eff = WINDOW_MAX;
    else eff = win_len;
    sample_ring[wr_ptr] = s;
    wr_ptr = (wr_ptr + 1) % WINDOW_MAX;
    if (taken != '1) taken = taken + 1'b1;
    w = '0;
    if (taken >= eff) begin
      hi  = s;
      lo  = s;
      pos = wr_ptr;
      for (int i = 0; i < eff; i++) begin
        pos = (pos == 0) ? WINDOW_MAX - 1 : pos - 1;
        if (sample_ring[pos] > hi) hi = sample_ring[pos];
        if (sample_ring[pos] < lo) lo = sample_ring[pos];
      end
      diff       = hi - lo;
      w.win_full = 1'b1;
      w.span     = diff[DATA_W-1:0];
      if (w.span < smallest) smallest = w.span;
      if (w.span >= span_threshold && qualifying != '1) qualifying = qualifying + 1'b1;
    end
    w.min_span = smallest;
    w.over_cnt = qualifying;
    w.reached  = (qualifying >= needed);
    w.is_last  = last;
    if (last) clear_sequence();
    return w;
  endfunction

  task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected 0x%h, got 0x%h", $time, name, want, got);
      fault_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      win_len        = 7'd1;
      span_threshold = '0;
      needed         = 32'd1;
      clear_sequence();
      range_words_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WINDOW_LEN:   win_len = cfg_data[WLEN_W-1:0];
          REG_THRESHOLD:    span_threshold = cfg_data;
          REG_NEEDED_COUNT: needed = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (range_words_due.size() == 0) begin
          $display("%0t: result word arrived with no sample outstanding", $time);
          fault_count++;
        end else begin
          due = range_words_due.pop_front();
          compare_field("out_window_ready", due.win_full, out_window_ready);
          compare_field("out_range", due.span, out_range);
          compare_field("out_min_range", due.min_span, out_min_range);
          compare_field("out_over_count", due.over_cnt, out_over_count);
          compare_field("out_reached", due.reached, out_reached);
          compare_field("out_is_last", due.is_last, out_is_last);
        end
      end
      if (in_valid && in_ready)
        range_words_due.push_back(predict_range_word(in_sample, in_last_sample));
    end
    pending <= range_words_due.size();
  end

endmodule

`default_nettype wire

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// Sliding window range tracker testbench
// Directed extremes followed by randomised sequences over a range of register
// settings, with bursty input and a stalling receiver; a checker alongside
// the block predicts and compares every result word.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import swrt_pkg::*;

  localparam int WINDOW_MAX = WINDOW_MAX_DEF;

  // Index 3 is not a register; a write there must leave everything alone.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam logic signed [DATA_W-1:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] S_MAX = 32'sh7fff_ffff;

  // After the last result we give the block comfortably longer than a word
  // that completes a window of WINDOW_MAX samples takes.
  localparam int SETTLE_CYCLES = WINDOW_MAX + 16;

  // No legal run goes this long without a word moving on some channel: the
  // worst case is a full-window scan plus a receiver stall plus a sender gap.
  localparam int IDLE_LIMIT = 3000;

  localparam int NUM_PHASES = 12;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [DATA_W-1:0]           cfg_data  = '0;

  logic                        in_valid       = 1'b0;
  logic                        in_ready;
  logic signed [DATA_W-1:0]    in_sample      = '0;
  logic                        in_last_sample = 1'b0;

  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic                        out_window_ready;
  logic [DATA_W-1:0]           out_range;
  logic [DATA_W-1:0]           out_min_range;
  logic [DATA_W-1:0]           out_over_count;
  logic                        out_reached;
  logic                        out_is_last;

  int mismatches;
  int pending;

  sliding_window_range_tracker #(.WINDOW_MAX(WINDOW_MAX)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .in_last_sample   (in_last_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_window_ready (out_window_ready),
    .out_range        (out_range),
    .out_min_range    (out_min_range),
    .out_over_count   (out_over_count),
    .out_reached      (out_reached),
    .out_is_last      (out_is_last)
  );

  swrt_range_checker #(.WINDOW_MAX(WINDOW_MAX)) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .in_last_sample   (in_last_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_window_ready (out_window_ready),
    .out_range        (out_range),
    .out_min_range    (out_min_range),
    .out_over_count   (out_over_count),
    .out_reached      (out_reached),
    .out_is_last      (out_is_last),
    .mismatches       (mismatches),
    .pending          (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Receiver. In one quarter of each pass of the 10-bit cycle counter the
  // receiver starts no new stall; otherwise it starts a stall of random length
  // now and then, so that stalls land on every stage of the block's scan.
  // --------------------------------------------------------------------------
  logic [9:0] rx_cycle   = '0;
  int         stall_left = 0;

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1'b1;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rx_cycle[9:8] != 2'd0 && $urandom_range(0, 3) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog. Counts cycles in which no word is accepted on any channel.
  // --------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sender state. The sender works in bursts; in a steady phase it sends
  // back to back with no gaps at all.
  // --------------------------------------------------------------------------
  int  burst_left = 0;
  bit  steady     = 1'b0;

  // Presents one configuration word and holds it until taken. The valid is
  // left high so that back-to-back writes need no second assignment in the
  // same step; the caller lowers it when the run of writes is done.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Writes all three registers, and optionally the unused index with junk.
  task automatic program_regs(input logic [DATA_W-1:0] len_word, input logic [DATA_W-1:0] thr,
                              input logic [DATA_W-1:0] need, input bit poke_spare);
    write_reg(REG_WINDOW_LEN, len_word);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_NEEDED_COUNT, need);
    if (poke_spare) write_reg(REG_SPARE, $urandom);
    cfg_valid <= 1'b0;
  endtask

  // Offers one sample word, inserting a random gap first when the current
  // burst is used up outside a steady phase.
  task automatic send_word(input logic signed [DATA_W-1:0] s, input logic last);
    if (!steady && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
    in_valid       <= 1'b1;
    in_sample      <= s;
    in_last_sample <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) burst_left--;
  endtask

  // Stops sending and waits until every predicted result word has been
  // taken, then lets the block settle before its registers are touched.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus and verdict.
  // --------------------------------------------------------------------------
  int unsigned              len_plan[NUM_PHASES] = '{2, 127, 5, 0, 1, 64, 9, 3, 65, 16, 4, 7};
  int unsigned              eff_len;
  int                       phase_budget;
  int                       seq_left;
  int                       sample_mode;
  logic [DATA_W-1:0]        band_base;
  logic [DATA_W-1:0]        thr_pick;
  logic [DATA_W-1:0]        need_pick;
  logic [DATA_W-1:0]        len_word;
  logic signed [DATA_W-1:0] s;

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: a window of one, so every word has a range of zero,
    // which meets the zero threshold and reaches a needed count of one.
    steady = 1'b1;
    send_word(S_MIN, 1'b0);
    send_word(S_MAX, 1'b0);
    send_word('0, 1'b1);

    // A window of three, with junk above the seven register bits. The most
    // negative and most positive samples give the widest possible range,
    // which alone meets an all-ones threshold; a needed count of zero keeps
    // reached high throughout.
    drain();
    program_regs(32'hffff_ff83, '1, '0, 1'b0);
    steady = 1'b0;
    send_word(S_MIN, 1'b0);
    send_word(S_MAX, 1'b0);
    send_word(S_MIN, 1'b0);
    send_word(32'sd5, 1'b0);
    send_word(32'sd5, 1'b0);
    send_word(32'sd5, 1'b1);
    // A sequence that ends before its window ever fills.
    send_word(-32'sd1, 1'b0);
    send_word(S_MAX, 1'b1);

    // A window length of zero acts as one; the spare index is written too.
    drain();
    program_regs(32'h0000_0080, 32'd1, 32'd2, 1'b1);
    send_word(32'sd7, 1'b0);
    send_word(32'sd7, 1'b0);
    send_word(-32'sd1, 1'b0);
    send_word(S_MIN, 1'b1);

    // Random phases. Each one waits for the block to empty, so the sender
    // also pauses until every result is back, then picks new settings.
    // Sequences run on across phase boundaries where the budget cuts them.
    seq_left = 0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      // Random junk above the register bits, the planned length below.
      len_word = {(DATA_W-WLEN_W)'($urandom), WLEN_W'(len_plan[ph])};
      case ($urandom_range(0, 3))
        0:       thr_pick = '0;
        1:       thr_pick = '1;
        2:       thr_pick = $urandom_range(0, 20);
        default: thr_pick = $urandom;
      endcase
      case ($urandom_range(0, 3))
        0:       need_pick = '0;
        1:       need_pick = 32'd1;
        2:       need_pick = $urandom_range(2, 12);
        default: need_pick = '1;
      endcase
      if (ph == 4) need_pick = '1;
      program_regs(len_word, thr_pick, need_pick, $urandom_range(0, 2) == 0);

      if (len_plan[ph] == 0) eff_len = 1;
      else if (len_plan[ph] > WINDOW_MAX) eff_len = WINDOW_MAX;
      else eff_len = len_plan[ph];
      phase_budget = (eff_len > 32) ? 80 : 35;
      steady       = (ph % 3 == 0);

      while (phase_budget > 0) begin
        if (seq_left == 0) begin
          // Mostly sequences no more than twelve words longer than the window; now
          // and then a long one so that the sample store wraps.
          if ($urandom_range(0, 5) == 0) seq_left = $urandom_range(70, 100);
          else seq_left = $urandom_range(1, eff_len + 12);
          sample_mode = $urandom_range(0, 2);
          band_base   = $urandom;
        end
        case (sample_mode)
          0: s = $urandom;
          // A narrow band gives small ranges that land either side of a
          // small threshold.
          1: s = band_base + $urandom_range(0, 15);
          default: begin
            case ($urandom_range(0, 3))
              0:       s = S_MIN;
              1:       s = S_MAX;
              2:       s = '0;
              default: s = -32'sd1;
            endcase
          end
        endcase
        send_word(s, seq_left == 1);
        seq_left--;
        phase_budget--;
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
